FILE: rtl/page_frame_stack_allocator_macros.svh
// ----------------------------------------------------------------------------
// Page frame stack allocator assertion macros
// Shorthand for clocked implications, sampled on i_clk with reset i_rst_n.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_STACK_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_STACK_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFSA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pfsa: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PFSA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pfsa: next-cycle check failed");

`endif

FILE: rtl/pfsa_pkg.sv
// ----------------------------------------------------------------------------
// pfsa_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package pfsa_pkg;

    localparam int DEF_STACK_DEPTH      = 8192;
    localparam int DEF_RESERVED_ENTRIES = 2;

    localparam int ADDR_W       = 32;
    localparam int PAGE_SHIFT   = 12;
    localparam int FRAME_W      = ADDR_W - PAGE_SHIFT;
    localparam int GROW_ENTRIES = 1024;
    localparam int USED_W       = 21;
    localparam int STATUS_W     = 3;
    localparam int CFG_IDX_W    = 3;

    localparam logic [ADDR_W-1:0] PAGE_BYTES = ADDR_W'(1) << PAGE_SHIFT;
    localparam logic [USED_W-1:0] USED_MAX   = '1;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_OOM      = 3'd1;
    localparam t_status ST_UNINIT   = 3'd2;
    localparam t_status ST_BAD_FREE = 3'd3;
    localparam t_status ST_IGNORED  = 3'd4;
    localparam t_status ST_ABSORBED = 3'd5;
    localparam t_status ST_DROPPED  = 3'd6;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_PAGING_ON      = 3'd0;
    localparam t_cfg_idx REG_BUMP_START     = 3'd1;
    localparam t_cfg_idx REG_RANGE_CHECK_ON = 3'd2;
    localparam t_cfg_idx REG_LOWEST_FRAME   = 3'd3;
    localparam t_cfg_idx REG_HIGHEST_FRAME  = 3'd4;

    typedef logic [1:0] t_grant_sel;

    localparam t_grant_sel GRANT_NONE = 2'd0;
    localparam t_grant_sel GRANT_BUMP = 2'd1;
    localparam t_grant_sel GRANT_POP  = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic       load;
        logic       bump;
        logic       pop;
        logic       push;
        logic       grow;
        logic       finish;
        t_grant_sel grant_sel;
        t_status    status;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_free;
        logic paging_on;
        logic bp_zero;
        logic reserve_hit;
        logic pop_ok;
        logic in_range;
        logic below_bp;
        logic stack_full;
        logic cap_max;
    } t_dp_status;

endpackage

`default_nettype wire

FILE: rtl/pfsa_ctrl.sv
// ----------------------------------------------------------------------------
// pfsa_ctrl
// Request sequencer: decodes each request against datapath status and
// issues bump, pop, push and grow steps until a result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module pfsa_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  pfsa_pkg::t_dp_status   i_sts,
    output logic                   o_busy,
    output pfsa_pkg::t_ctrl_cmd    o_ctl
);
    import pfsa_pkg::*;

    localparam logic [1:0] S_IDLE     = 2'd0;
    localparam logic [1:0] S_EXEC     = 2'd1;
    localparam logic [1:0] S_POP_WAIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    t_ctrl_cmd  ctl;

    always_comb begin
        n_state       = r_state;
        ctl           = '0;
        ctl.grant_sel = GRANT_NONE;
        ctl.status    = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    ctl.load = 1'b1;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state    = S_IDLE;
                ctl.finish = 1'b1;
                if (i_sts.is_free) begin
                    priority if (!i_sts.paging_on) begin
                        ctl.status = ST_BAD_FREE;
                    end else if (i_sts.below_bp) begin
                        ctl.status = ST_IGNORED;
                    end else if (!i_sts.in_range) begin
                        ctl.status = ST_BAD_FREE;
                    end else if (i_sts.stack_full && i_sts.cap_max) begin
                        ctl.status = ST_DROPPED;
                    end else if (i_sts.stack_full) begin
                        ctl.grow   = 1'b1;
                        ctl.status = ST_ABSORBED;
                    end else begin
                        ctl.push   = 1'b1;
                    end
                end else begin
                    priority if (i_sts.bp_zero) begin
                        ctl.status = ST_UNINIT;
                    end else if (!i_sts.paging_on) begin
                        // Take the page at the pointer; skip it and loop if out of range
                        ctl.bump = 1'b1;
                        if (i_sts.in_range) begin
                            ctl.grant_sel = GRANT_BUMP;
                        end else begin
                            ctl.finish = 1'b0;
                            n_state    = S_EXEC;
                        end
                    end else if (i_sts.reserve_hit) begin
                        ctl.status = ST_OOM;
                    end else begin
                        ctl.pop = 1'b1;
                        if (i_sts.pop_ok) begin
                            ctl.grant_sel = GRANT_POP;
                        end else begin
                            // Discard the entry; wait for the read of the next one
                            ctl.finish = 1'b0;
                            n_state    = S_POP_WAIT;
                        end
                    end
                end
            end
            S_POP_WAIT: begin
                n_state = S_EXEC;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_ctl  = ctl;

endmodule

`default_nettype wire

FILE: rtl/pfsa_dp.sv
// ----------------------------------------------------------------------------
// pfsa_dp
// Datapath: configuration registers, bump pointer, free-frame stack memory,
// stack count and capacity, used-page counter and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pfsa_dp #(
    parameter int STACK_DEPTH      = pfsa_pkg::DEF_STACK_DEPTH,
    parameter int RESERVED_ENTRIES = pfsa_pkg::DEF_RESERVED_ENTRIES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [pfsa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pfsa_pkg::ADDR_W-1:0]  i_cfg_data,
    input  logic                         i_cmd,
    input  logic [pfsa_pkg::ADDR_W-1:0]  i_frame_addr,
    input  pfsa_pkg::t_ctrl_cmd          i_ctl,
    output pfsa_pkg::t_dp_status         o_sts,
    output logic                         o_done,
    output logic [pfsa_pkg::ADDR_W-1:0]  o_granted_addr,
    output logic [pfsa_pkg::STATUS_W-1:0] o_status,
    output logic [pfsa_pkg::USED_W-1:0]  o_used_count
);
    import pfsa_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    // Configuration
    logic              r_paging_on;
    logic              r_range_chk;
    logic [ADDR_W-1:0] r_lowest;
    logic [ADDR_W-1:0] r_highest;

    // Allocator state
    logic [ADDR_W-1:0] r_bp,    n_bp;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_cap,   n_cap;
    logic [USED_W-1:0] r_used,  n_used;

    // Request and result
    logic              r_cmd;
    logic [ADDR_W-1:0] r_addr;
    logic              r_done;
    logic [ADDR_W-1:0] r_granted;
    t_status           r_status;

    // Stack memory
    logic [FRAME_W-1:0] mem [STACK_DEPTH];
    logic [FRAME_W-1:0] r_rd_data;
    logic [IDX_W-1:0]   rd_idx;
    logic [IDX_W-1:0]   wr_idx;

    logic [ADDR_W-1:0] pop_addr;
    logic [ADDR_W-1:0] chk_addr;
    logic              out_of_range;
    logic [CNT_W:0]    cap_sum;
    logic [ADDR_W-1:0] granted;

    assign rd_idx   = IDX_W'(r_count - CNT_W'(1));
    assign wr_idx   = r_count[IDX_W-1:0];
    assign pop_addr = {r_rd_data, PAGE_SHIFT'(0)};

    // One range comparator, shared by free, bump and pop checks
    assign chk_addr     = r_cmd ? r_addr : (r_paging_on ? pop_addr : r_bp);
    assign out_of_range = r_range_chk && ((chk_addr > r_highest) || (chk_addr < r_lowest));

    always_comb begin
        o_sts             = '0;
        o_sts.is_free     = r_cmd;
        o_sts.paging_on   = r_paging_on;
        o_sts.bp_zero     = (r_bp == '0);
        o_sts.reserve_hit = (r_count <= CNT_W'(RESERVED_ENTRIES));
        o_sts.pop_ok      = (r_rd_data != '0) && !out_of_range;
        o_sts.in_range    = !out_of_range;
        o_sts.below_bp    = (r_addr < r_bp);
        o_sts.stack_full  = (r_count >= r_cap);
        o_sts.cap_max     = (r_cap >= CNT_W'(STACK_DEPTH));
    end

    always_comb begin
        n_bp = r_bp;
        if (i_cfg_we && (i_cfg_index == REG_BUMP_START)) begin
            n_bp = {i_cfg_data[ADDR_W-1:PAGE_SHIFT] + FRAME_W'(1), PAGE_SHIFT'(0)};
        end else if (i_ctl.bump) begin
            n_bp = r_bp + PAGE_BYTES;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_ctl.pop) begin
            n_count = r_count - CNT_W'(1);
        end else if (i_ctl.push) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_comb begin
        cap_sum = {1'b0, r_cap} + (CNT_W + 1)'(GROW_ENTRIES);
        n_cap   = r_cap;
        if (i_ctl.grow) begin
            if (cap_sum > (CNT_W + 1)'(STACK_DEPTH)) begin
                n_cap = CNT_W'(STACK_DEPTH);
            end else begin
                n_cap = cap_sum[CNT_W-1:0];
            end
        end
    end

    // Saturate at both ends
    always_comb begin
        n_used = r_used;
        if ((i_ctl.bump || i_ctl.pop) && (r_used != USED_MAX)) begin
            n_used = r_used + USED_W'(1);
        end else if (i_ctl.push && (r_used != '0)) begin
            n_used = r_used - USED_W'(1);
        end
    end

    always_comb begin
        case (i_ctl.grant_sel)
            GRANT_BUMP: granted = r_bp;
            GRANT_POP:  granted = pop_addr;
            default:    granted = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paging_on <= 1'b0;
            r_range_chk <= 1'b0;
            r_lowest    <= '1;
            r_highest   <= '0;
            r_bp        <= '0;
            r_count     <= '0;
            r_cap       <= '0;
            r_used      <= '0;
            r_done      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_PAGING_ON:      r_paging_on <= i_cfg_data[0];
                    REG_RANGE_CHECK_ON: r_range_chk <= i_cfg_data[0];
                    REG_LOWEST_FRAME:   r_lowest    <= i_cfg_data;
                    REG_HIGHEST_FRAME:  r_highest   <= i_cfg_data;
                    default: ;
                endcase
            end
            r_bp    <= n_bp;
            r_count <= n_count;
            r_cap   <= n_cap;
            r_used  <= n_used;
            r_done  <= i_ctl.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= i_cmd;
            r_addr <= i_frame_addr;
        end
        if (i_ctl.finish) begin
            r_granted <= granted;
            r_status  <= i_ctl.status;
        end
    end

    // Read the top entry every cycle; writes land above it
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            mem[wr_idx] <= r_addr[ADDR_W-1:PAGE_SHIFT];
        end
        r_rd_data <= mem[rd_idx];
    end

    assign o_done         = r_done;
    assign o_granted_addr = r_granted;
    assign o_status       = r_status;
    assign o_used_count   = r_used;

endmodule

`default_nettype wire

FILE: rtl/page_frame_stack_allocator.sv
// ----------------------------------------------------------------------------
// page_frame_stack_allocator
// Physical page-frame allocator: bump allocation with paging off, free-frame
// stack with paging on; keeps a count of pages in use.
//
//   Channel   Handshake                    Payload
//   request   i_start / o_busy             i_cmd, i_frame_addr
//   result    o_done (one-cycle strobe)    o_granted_addr, o_status, o_used_count
//   config    i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// A request passes through the execute state and the registered done flag before its
// result strobe; the next request is taken in the cycle the result shows.
// A bump allocation repeats the execute state for each out-of-range page skipped.
// A pop passes through a wait state for each discarded entry, for the registered stack read.
// Reset (i_rst_n low, synchronous) clears control state; the stack memory is
// not cleared and needs no clearing pass. Results cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module page_frame_stack_allocator #(
    parameter int STACK_DEPTH      = pfsa_pkg::DEF_STACK_DEPTH,
    parameter int RESERVED_ENTRIES = pfsa_pkg::DEF_RESERVED_ENTRIES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic                           i_cmd,
    input  logic [pfsa_pkg::ADDR_W-1:0]    i_frame_addr,
    output logic                           o_done,
    output logic [pfsa_pkg::ADDR_W-1:0]    o_granted_addr,
    output logic [pfsa_pkg::STATUS_W-1:0]  o_status,
    output logic [pfsa_pkg::USED_W-1:0]    o_used_count,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pfsa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pfsa_pkg::ADDR_W-1:0]    i_cfg_data
);
    import pfsa_pkg::*;

    t_ctrl_cmd  ctl;
    t_dp_status sts;
    logic       busy;

    assign o_busy      = busy;
    assign o_cfg_ready = !busy;

    pfsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_busy  (busy),
        .o_ctl   (ctl)
    );

    pfsa_dp #(
        .STACK_DEPTH      (STACK_DEPTH),
        .RESERVED_ENTRIES (RESERVED_ENTRIES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid && !busy),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (i_cmd),
        .i_frame_addr   (i_frame_addr),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .o_done         (o_done),
        .o_granted_addr (o_granted_addr),
        .o_status       (o_status),
        .o_used_count   (o_used_count)
    );

endmodule

`default_nettype wire

FILE: rtl/pfsa_checker.sv
// ----------------------------------------------------------------------------
// pfsa_checker
// Port-level checks on request/result sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "page_frame_stack_allocator_macros.svh"

module pfsa_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_start,
    input logic                          o_busy,
    input logic                          o_done,
    input logic [pfsa_pkg::ADDR_W-1:0]   o_granted_addr,
    input logic [pfsa_pkg::STATUS_W-1:0] o_status
);
    import pfsa_pkg::*;

    // An accepted transaction keeps the block busy until its result
    `PFSA_ASSERT_NEXT(a_accept_busy, i_start && !o_busy, o_busy)
    `PFSA_ASSERT_NEXT(a_busy_ends_in_result, o_busy, o_busy || o_done)
    // Result cycle frees the request side
    `PFSA_ASSERT_SAME(a_done_idle, o_done, !o_busy)
    // No address leaks out with a failure
    `PFSA_ASSERT_SAME(a_fail_no_grant, o_done && (o_status != ST_OK), o_granted_addr == '0)

endmodule

bind page_frame_stack_allocator pfsa_checker u_pfsa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .o_done         (o_done),
    .o_granted_addr (o_granted_addr),
    .o_status       (o_status)
);

`default_nettype wire
